// File: design/rcmd_pkg.sv
package rcmd_pkg;

    localparam int unsigned HISTORY_BYTES_DEF = 16777216;
    localparam int unsigned BUCKET_COUNT      = 65536;
    localparam int unsigned SLOTS_PER_BUCKET  = 15;

    localparam int unsigned POS_W  = 24;
    localparam int unsigned CTX_W  = 16;
    localparam int unsigned HEAD_W = 4;
    localparam int unsigned LEN_W  = 5;

    localparam logic [8:0]       REPEAT_SYM = 9'd511;
    localparam logic [31:0]      HASH_MUL   = 32'd13131;
    localparam logic [LEN_W-1:0] MIN_MATCH  = LEN_W'(2);
    localparam logic [HEAD_W-1:0] LAST_SLOT = HEAD_W'(SLOTS_PER_BUCKET - 1);

    // one bucket: ring head plus all stored positions
    typedef struct packed {
        logic [HEAD_W-1:0]                        head;
        logic [SLOTS_PER_BUCKET-1:0][POS_W-1:0]   slot;
    } t_bucket_row;

    typedef struct packed {
        logic [HEAD_W-1:0] slot;
        logic [LEN_W-1:0]  len;
    } t_match_code;

    // code / 15 through a reciprocal multiply, exact for codes up to 254
    function automatic t_match_code split_code(input logic [7:0] code);
        logic [15:0]       prod;
        logic [LEN_W-1:0]  quot;
        logic [7:0]        rem;
        t_match_code       res;
        prod     = 16'(code) * 16'd137;
        quot     = prod[15:11];
        rem      = code - ((8'(quot) << 4) - 8'(quot));
        res.slot = rem[HEAD_W-1:0];
        res.len  = quot + MIN_MATCH;
        return res;
    endfunction

endpackage

// File: design/rolz_context_match_decoder_unit.sv
// channel   dir  tdata                  tlast          tuser
// s_axis    in   [8:0] symbol           end_of_block   -
// m_axis    out  [7:0] out_byte         last           -
//
// after reset a clearing pass zeroes the bucket and last-char memories, one
// row a cycle over all 65536 rows; no item is accepted until it ends
// an item is accepted in the idle state; a literal or repeat item then takes a
// read state and a write state, and a match takes a bucket read and a source
// select, then a read state and a read-modify-write state on the memories
// for every byte
// the output register holds one byte; the byte loop waits while it is full
// and not taken, and a new item is accepted while the last byte still waits
module rolz_context_match_decoder_unit
    import rcmd_pkg::*;
#(
    parameter int unsigned HISTORY_BYTES = HISTORY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [8:0] symbol, rest zero
    input  logic        s_axis_tlast,   // end_of_block
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // last byte of this item
);

    // history depth is taken as a power of two
    localparam int unsigned HIST_AW = $clog2(HISTORY_BYTES);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MSTART = 3'd2;
    localparam logic [2:0] S_MSRC   = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;
    localparam logic [2:0] S_EXEC   = 3'd5;

    // memories
    logic [7:0]  mem_hist   [HISTORY_BYTES];
    t_bucket_row mem_bucket [BUCKET_COUNT];
    logic [7:0]  mem_lc     [BUCKET_COUNT];

    // control state
    logic [2:0]       r_state, n_state;
    logic [CTX_W-1:0] r_clr_addr;
    logic             r_out_valid;
    logic [CTX_W-1:0] r_hash, r_l2;
    logic [POS_W-1:0] r_pos;

    // item payload
    logic [8:0]        r_sym;
    logic              r_eob;
    logic [HEAD_W-1:0] r_slot;
    logic [LEN_W-1:0]  r_len_left;
    logic [POS_W-1:0]  r_src;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    // registered read data
    t_bucket_row r_row;
    logic [7:0]  r_lc_q;
    logic [7:0]  r_hist_q;

    logic              w_accept;
    logic              w_fire;
    logic              w_is_match;
    logic              w_is_repeat;
    logic              w_last;
    logic [7:0]        w_byte;
    t_match_code       w_code;
    logic [HEAD_W:0]   w_idx_sum;
    logic [HEAD_W-1:0] w_src_idx;
    logic [HEAD_W-1:0] w_new_head;
    t_bucket_row       w_row_wdata;
    logic              w_row_we;
    logic [CTX_W-1:0]  w_row_waddr;
    logic [7:0]        w_lc_wdata;
    logic [CTX_W-1:0]  w_lc_waddr;
    logic [31:0]       w_prod;
    logic              w_row_re;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_fire        = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    assign w_is_repeat = (r_sym == REPEAT_SYM);
    assign w_is_match  = r_sym[8] && !w_is_repeat;
    assign w_last      = !w_is_match || (r_len_left == LEN_W'(1));
    assign w_code      = split_code(s_axis_tdata[7:0]);

    // literal, last-char lookup or copied history byte
    always_comb begin
        priority if (w_is_repeat) begin
            w_byte = r_lc_q;
        end else if (!r_sym[8]) begin
            w_byte = r_sym[7:0];
        end else begin
            w_byte = r_hist_q;
        end
    end

    // slot i of a bucket sits at (head + i) mod 15
    assign w_idx_sum  = {1'b0, r_row.head} + {1'b0, r_slot};
    assign w_src_idx  = (w_idx_sum >= (HEAD_W+1)'(SLOTS_PER_BUCKET))
                        ? HEAD_W'(w_idx_sum - (HEAD_W+1)'(SLOTS_PER_BUCKET))
                        : w_idx_sum[HEAD_W-1:0];
    // head steps back one slot for every pushed byte
    assign w_new_head = (r_row.head == '0) ? LAST_SLOT : r_row.head - HEAD_W'(1);

    assign w_prod = 32'(r_l2) * HASH_MUL;

    // bucket and last-char write ports, shared with the clearing pass
    always_comb begin
        w_row_wdata = r_row;
        w_row_wdata.head = w_new_head;
        w_row_wdata.slot[w_new_head] = r_pos;
        w_row_waddr = r_hash;
        w_lc_waddr  = r_l2;
        w_lc_wdata  = w_byte;
        w_row_we    = w_fire;
        if (r_state == S_CLEAR) begin
            w_row_wdata = '0;
            w_row_waddr = r_clr_addr;
            w_lc_waddr  = r_clr_addr;
            w_lc_wdata  = '0;
            w_row_we    = 1'b1;
        end
    end

    assign w_row_re = (r_state == S_MSTART) || (r_state == S_FETCH);

    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            mem_bucket[w_row_waddr] <= w_row_wdata;
            mem_lc[w_lc_waddr]      <= w_lc_wdata;
        end
        if (w_row_re) begin
            r_row <= mem_bucket[r_hash];
        end
        if (r_state == S_FETCH) begin
            r_lc_q <= mem_lc[r_l2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            mem_hist[r_pos[HIST_AW-1:0]] <= w_byte;
        end
        if (r_state == S_FETCH) begin
            r_hist_q <= mem_hist[r_src[HIST_AW-1:0]];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (&r_clr_addr) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (s_axis_tdata[8] && (s_axis_tdata[8:0] != REPEAT_SYM))
                              ? S_MSTART : S_FETCH;
                end
            end
            S_MSTART: n_state = S_MSRC;
            S_MSRC:   n_state = S_FETCH;
            S_FETCH:  n_state = S_EXEC;
            S_EXEC: begin
                if (w_fire) n_state = w_last ? S_IDLE : S_FETCH;
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_hash      <= '0;
            r_l2        <= '0;
            r_pos       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + CTX_W'(1);
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                r_hash <= w_prod[CTX_W-1:0] + CTX_W'(w_byte);
                r_l2   <= {r_l2[7:0], w_byte};
                r_pos  <= (w_last && r_eob) ? '0 : r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sym      <= s_axis_tdata[8:0];
            r_eob      <= s_axis_tlast;
            r_slot     <= w_code.slot;
            r_len_left <= w_code.len;
        end else if (w_fire) begin
            r_len_left <= r_len_left - LEN_W'(1);
        end
        if (r_state == S_MSRC) begin
            r_src <= r_row.slot[w_src_idx];
        end else if (w_fire) begin
            r_src <= r_src + POS_W'(1);
        end
        if (w_fire) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_last) |=> (r_state == S_IDLE))
        else $error("item did not end after its last byte");

    a_match_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FETCH) && w_is_match) |-> (r_len_left != '0))
        else $error("match byte fetched with no length left");

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (m_axis_tvalid && (m_axis_tlast == $past(w_last))))
        else $error("emitted byte not presented on the output");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("input ready during clearing pass");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rcmd_pkg::*;

    // symbol codes on the input stream
    localparam logic [8:0] MATCH_FIRST = 9'd256;
    localparam logic [8:0] LIT_LAST    = 9'd255;

    // cycles with no handshake on either side before the run is abandoned;
    // covers the clearing pass of all 65536 rows after reset several times over
    localparam int unsigned STALL_LIMIT = 300000;
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       tail;
    } t_decoded_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [8:0] symbol, rest zero
    logic        s_axis_tlast = 1'b0;   // end_of_block
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] out_byte
    logic        m_axis_tlast;          // last byte of this item

    // decoder state mirrored in the testbench
    bit [7:0]     hist_mem [int unsigned];   // only written entries exist
    bit [23:0]    slot_pos [int unsigned];   // key {context, ring index}
    bit [3:0]     ring_head [65536];
    bit [7:0]     follow_byte [65536];
    bit [15:0]    ctx_hash;
    bit [15:0]    prev_pair;
    bit [23:0]    wr_pos;

    t_decoded_byte pending_bytes [$];
    t_decoded_byte want;
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   burst_left = 0;

    // receiver side
    int unsigned   rx_hold_left = 0;
    int unsigned   rx_phase_left = 0;
    t_rx_mode      rx_mode = RX_OPEN;

    always #4 i_clk = ~i_clk;

    rolz_context_match_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // byte-level prediction
    // ------------------------------------------------------------------

    function automatic int unsigned hist_slot(input bit [23:0] pos);
        return pos % HISTORY_BYTES_DEF;
    endfunction

    // one emitted byte: history write, ring update, follow table, hash, position
    function automatic void record_byte(input bit [7:0] b, input bit tail);
        bit [3:0] h;
        hist_mem[hist_slot(wr_pos)] = b;
        h = (ring_head[ctx_hash] == 4'd0) ? LAST_SLOT : ring_head[ctx_hash] - 4'd1;
        ring_head[ctx_hash] = h;
        slot_pos[{ctx_hash, h}] = wr_pos;
        follow_byte[prev_pair] = b;
        ctx_hash = 16'(32'(prev_pair) * HASH_MUL + 32'(b));
        prev_pair = {prev_pair[7:0], b};
        wr_pos = wr_pos + 24'd1;
        pending_bytes.push_back('{data: b, tail: tail});
    endfunction

    function automatic int unsigned copy_len(input bit [8:0] sym);
        return (sym - MATCH_FIRST) / SLOTS_PER_BUCKET + MIN_MATCH;
    endfunction

    // copy source: ring slot counted from the current head of this context
    function automatic bit [23:0] copy_origin(input bit [8:0] sym);
        bit [3:0] idx;
        idx = 4'((ring_head[ctx_hash] + (sym - MATCH_FIRST) % SLOTS_PER_BUCKET)
                 % SLOTS_PER_BUCKET);
        return slot_pos.exists({ctx_hash, idx}) ? slot_pos[{ctx_hash, idx}] : 24'd0;
    endfunction

    // a copy may only read history that exists, either from earlier items
    // or from bytes this same copy has already written (overlap)
    function automatic bit copy_is_defined(input bit [8:0] sym);
        bit [23:0]   src;
        bit [23:0]   p;
        bit [23:0]   ahead;
        int unsigned len;
        src = copy_origin(sym);
        len = copy_len(sym);
        for (int k = 0; k < len; k++) begin
            p = src + 24'(k);
            ahead = p - wr_pos;
            if (!hist_mem.exists(hist_slot(p)) && ahead >= k)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void decode_symbol(input bit [8:0] sym, input bit eob);
        bit [23:0]   src;
        bit [7:0]    b;
        int unsigned len;
        if (sym == REPEAT_SYM) begin
            record_byte(follow_byte[prev_pair], 1'b1);
        end else if (sym <= LIT_LAST) begin
            record_byte(sym[7:0], 1'b1);
        end else begin
            src = copy_origin(sym);
            len = copy_len(sym);
            for (int k = 0; k < len; k++) begin
                b = hist_mem.exists(hist_slot(src)) ? hist_mem[hist_slot(src)] : 8'd0;
                record_byte(b, k == len - 1);
                src = src + 24'd1;
            end
        end
        if (eob)
            wr_pos = 24'd0;
    endfunction

    // a literal from a narrow alphabet so contexts recur and buckets fill
    function automatic bit [8:0] alphabet_literal();
        return 9'($urandom_range(8'h61, 8'h64));
    endfunction

    function automatic bit [8:0] pick_match();
        bit [8:0] cand;
        for (int t = 0; t < 12; t++) begin
            if ($urandom_range(0, 9) < 7)
                cand = MATCH_FIRST + 9'($urandom_range(0, 59));
            else
                cand = MATCH_FIRST + 9'($urandom_range(0, 254));
            if (copy_is_defined(cand))
                return cand;
        end
        return alphabet_literal();
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // one item; a copy that would read unwritten history becomes a literal
    task automatic send_item(input bit [8:0] sym, input bit eob);
        int unsigned gap;
        if (sym > LIT_LAST && sym != REPEAT_SYM && !copy_is_defined(sym))
            sym = alphabet_literal();
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        decode_symbol(sym, eob);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, sym};
        s_axis_tlast  <= eob;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
    endtask

    // drop valid and hold off until every predicted byte has come out;
    // always waits on the clock before it checks, so valid is never lowered and raised in one step
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_bytes.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // receiver: stall pattern that changes mode in stretches, plus long holds
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_phase_left = $urandom_range(16, 120);
            end
            rx_phase_left--;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output check against the oldest predicted byte
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (want.data !== m_axis_tdata || want.tail !== m_axis_tlast) begin
                    $display("%0t: byte mismatch: expected %02h last %0b, actual %02h last %0b",
                             $time, want.data, want.tail, m_axis_tdata, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // literal extremes and the repeat code, first on empty tables
    task automatic test_literals_and_repeat();
        send_item(REPEAT_SYM, 1'b0);
        send_item(9'd0, 1'b0);
        send_item(LIT_LAST, 1'b0);
        for (int i = 0; i < 4; i++) begin
            send_item(9'h061, 1'b0);
            send_item(9'h062, 1'b0);
        end
        send_item(REPEAT_SYM, 1'b0);
        wait_drain();
    endtask

    // newest and oldest ring slots, shortest and longest copies, overlap
    task automatic test_match_codes();
        send_item(MATCH_FIRST, 1'b0);
        send_item(MATCH_FIRST + 9'd14, 1'b0);
        send_item(9'd510, 1'b0);
        send_item(MATCH_FIRST + 9'd45, 1'b0);
        wait_drain();
    endtask

    // end of block on each kind of item; only the position restarts
    task automatic test_end_of_block();
        send_item(9'h063, 1'b1);
        send_item(9'h061, 1'b0);
        send_item(9'h062, 1'b0);
        send_item(MATCH_FIRST + 9'd30, 1'b1);
        send_item(REPEAT_SYM, 1'b1);
        send_item(MATCH_FIRST, 1'b0);
        wait_drain();
    endtask

    // mostly copies and repeats over a narrow alphabet, some full-range noise
    task automatic test_random_traffic(input int unsigned count);
        bit [8:0]    sym;
        bit          eob;
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            eob  = ($urandom_range(0, 29) == 0);
            if (pick < 30)
                sym = alphabet_literal();
            else if (pick < 40)
                sym = 9'($urandom_range(0, 255));
            else if (pick < 52)
                sym = REPEAT_SYM;
            else
                sym = pick_match();
            send_item(sym, eob);
        end
        wait_drain();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        rx_hold_left = 600;
        for (int i = 0; i < 24; i++)
            send_item(($urandom_range(0, 2) == 0) ? alphabet_literal() : pick_match(),
                      1'b0);
        wait_drain();
    endtask

    initial begin
        ctx_hash  = '0;
        prev_pair = '0;
        wr_pos    = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_literals_and_repeat();
        test_match_codes();
        test_end_of_block();
        test_random_traffic(265);
        test_backpressure();

        // nothing is expected now; any late byte is caught by the checker
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
